// ===== design/repsup_pkg.sv =====
// repsup_pkg: shared types and constants for the repeat event suppressor
// used by repsup_ctrl, repsup_dp and repeat_event_suppressor_core
package repsup_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int KEY_BITS_DEF    = 32;

	// fixed field widths of the stream payloads
	localparam int KEY_W   = 32;
	localparam int COUNT_W = 16;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

	// output tuser bit positions
	localparam int UB_PASSED = 0;
	localparam int UB_REPORT = 1;

	// controller -> datapath commands
	typedef struct packed {
		logic load;         // capture input transfer, clear flush pointer
		logic cmp;          // register key compare result
		logic upd;          // apply event update and load its result
		logic sel_ptr;      // table read address comes from flush pointer
		logic ptr_inc;      // advance flush pointer
		logic emit_report;  // load report result for entry at pointer
		logic emit_term;    // load terminator result, empty the table
	} cmd_t;

	// datapath -> controller status
	typedef struct packed {
		logic tick;         // input transfer is a period tick
		logic rep_due;      // entry at pointer has count above one
		logic ptr_end;      // pointer has reached the fill count
		logic out_free;     // output register can take a result
	} status_t;

endpackage

// ===== design/repsup_ctrl.sv =====
// repsup_ctrl: sequencing state machine of the repeat event suppressor
// depends on repsup_pkg (cmd_t, status_t)
module repsup_ctrl
	import repsup_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  status_t status,
	output cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CMP   = 2'd1;
	localparam logic [1:0] ST_UPD   = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		s_tready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load  = 1'b1;
					state_nxt = status.tick ? ST_FLUSH : ST_CMP;
				end
			end
			ST_CMP: begin
				cmd.cmp   = 1'b1;
				state_nxt = ST_UPD;
			end
			ST_UPD: begin
				if (status.out_free) begin
					cmd.upd   = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				cmd.sel_ptr = 1'b1;
				if (status.ptr_end) begin
					if (status.out_free) begin
						cmd.emit_term = 1'b1;
						state_nxt     = ST_IDLE;
					end
				end else if (status.rep_due) begin
					// repeated key: wait for the output slot before moving on
					if (status.out_free) begin
						cmd.emit_report = 1'b1;
						cmd.ptr_inc     = 1'b1;
					end
				end else begin
					cmd.ptr_inc = 1'b1;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== design/repsup_dp.sv =====
// repsup_dp: key table, parallel compare, flush pointer and output register
// depends on repsup_pkg (cmd_t, status_t, field widths)
module repsup_dp
	import repsup_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int KEY_BITS    = KEY_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [0:0]           s_tuser,
	input  logic [KEY_W-1:0]     s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [KEY_W+COUNT_W-1:0] m_tdata,
	output logic [1:0]           m_tuser,
	output logic                 m_tlast,
	input  cmd_t                 cmd,
	output status_t              status
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

	logic [KEY_BITS-1:0] keys_q [TABLE_DEPTH];
	logic [COUNT_W-1:0]  counts_q [TABLE_DEPTH];
	logic [KEY_BITS-1:0] key_q;
	logic [CNT_W-1:0]    used_q;
	logic [CNT_W-1:0]    ptr_q;
	logic                hit_s1;
	logic [IDX_W-1:0]    idx_s1;

	logic [TABLE_DEPTH-1:0] hit_vec;
	logic [IDX_W-1:0]       hit_idx;
	logic [IDX_W-1:0]       rd_idx;
	logic [COUNT_W-1:0]     rd_cnt;
	logic [KEY_BITS-1:0]    rd_key;
	logic                   out_free;

	logic                    m_tvalid_q;
	logic [KEY_W+COUNT_W-1:0] m_tdata_q;
	logic [1:0]              m_tuser_q;
	logic                    m_tlast_q;

	// one comparator per entry; only filled entries may match
	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			hit_vec[i] = (CNT_W'(i) < used_q) && (keys_q[i] == key_q);
		end
	end

	// stored keys are unique, so the match is one-hot and an or-tree encodes it
	always_comb begin
		for (int b = 0; b < IDX_W; b++) begin
			hit_idx[b] = 1'b0;
			for (int i = 0; i < TABLE_DEPTH; i++) begin
				if (((i >> b) & 1) == 1) begin
					hit_idx[b] = hit_idx[b] | hit_vec[i];
				end
			end
		end
	end

	assign rd_idx   = cmd.sel_ptr ? ptr_q[IDX_W-1:0] : idx_s1;
	assign rd_cnt   = counts_q[rd_idx];
	assign rd_key   = keys_q[rd_idx];
	assign out_free = !m_tvalid_q || m_tready;

	assign status.tick     = s_tuser[0];
	assign status.rep_due  = rd_cnt > COUNT_ONE;
	assign status.ptr_end  = ptr_q == used_q;
	assign status.out_free = out_free;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			ptr_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				ptr_q <= '0;
			end else if (cmd.ptr_inc) begin
				ptr_q <= ptr_q + CNT_W'(1);
			end
			if (cmd.emit_term) begin
				used_q <= '0;
			end else if (cmd.upd && !hit_s1 && (used_q < DEPTH_C)) begin
				used_q <= used_q + CNT_W'(1);
			end
			if (cmd.upd || cmd.emit_report || cmd.emit_term) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload and table
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= KEY_BITS'(s_tdata);
		end
		if (cmd.cmp) begin
			hit_s1 <= |hit_vec;
			idx_s1 <= hit_idx;
		end
		if (cmd.upd) begin
			if (hit_s1) begin
				if (rd_cnt != COUNT_MAX) begin
					counts_q[idx_s1] <= rd_cnt + COUNT_ONE;
				end
			end else if (used_q < DEPTH_C) begin
				keys_q[used_q[IDX_W-1:0]]   <= key_q;
				counts_q[used_q[IDX_W-1:0]] <= COUNT_ONE;
			end
		end
		if (cmd.upd) begin
			m_tdata_q <= '0;
			m_tuser_q <= 2'(!hit_s1) << UB_PASSED;
			m_tlast_q <= 1'b1;
		end else if (cmd.emit_report) begin
			m_tdata_q <= {rd_cnt, KEY_W'(rd_key)};
			m_tuser_q <= 2'(1) << UB_REPORT;
			m_tlast_q <= 1'b0;
		end else if (cmd.emit_term) begin
			m_tdata_q <= '0;
			m_tuser_q <= '0;
			m_tlast_q <= 1'b1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ===== design/repeat_event_suppressor_core.sv =====
// repeat_event_suppressor_core: top level of the repeat event suppressor
// depends on repsup_pkg, repsup_ctrl and repsup_dp
//
// channel  dir  handshake          payload
// s_*      in   tvalid/tready      tdata[31:0] key, tuser[0] kind (1 = tick)
// m_*      out  tvalid/tready      tdata[31:0] report_key, [47:32] report_count,
//                                  tuser[0] passed, [1] report_valid, tlast last
//
// an event passes through three steps: accept, parallel key compare over the table, update
// a tick walks the table with the flush pointer, one entry a cycle unless a report waits for the output slot
// reset (arst_n low) empties the table through its fill count; no clearing pass
// input is accepted only when the previous item is done with the table
// a stalled output holds its result; the update or report waits for the slot to free
module repeat_event_suppressor_core
	import repsup_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int KEY_BITS    = KEY_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [KEY_W-1:0]          s_tdata,   // [31:0] key
	input  logic [0:0]                s_tuser,   // [0] kind
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [KEY_W+COUNT_W-1:0]  m_tdata,   // [31:0] report_key, [47:32] report_count
	output logic [1:0]                m_tuser,   // [0] passed, [1] report_valid
	output logic                      m_tlast
);

	cmd_t    cmd;
	status_t status;

	repsup_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	repsup_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.KEY_BITS    (KEY_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cmd      (cmd),
		.status   (status)
	);

	// a report item never passes and never ends the run
	a_report_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[UB_REPORT] |-> !m_tuser[UB_PASSED] && !m_tlast)
		else $error("report item with passed or last set");

	// at most one datapath action per cycle
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.cmp, cmd.upd, cmd.emit_report, cmd.emit_term}))
		else $error("conflicting datapath commands");

	// results only go into a free output register
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.upd || cmd.emit_report || cmd.emit_term) |-> status.out_free)
		else $error("result loaded over a pending transfer");

	// an accepted event occupies the table through its compare and update states
	a_event_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tuser[0] |=> !s_tready ##1 !s_tready)
		else $error("input accepted during event update");

endmodule

// ===== bench/repeat_event_suppressor_core_tb.sv =====
`timescale 1ns / 100ps
// repeat_event_suppressor_core_tb: self-checking bench for the repeat event suppressor
// depends on repsup_pkg and repeat_event_suppressor_core; predicts pass, report and flush results
module repeat_event_suppressor_core_tb;
	import repsup_pkg::*;

	localparam bit KIND_EVENT = 1'b0;
	localparam bit KIND_TICK  = 1'b1;
	localparam int DEPTH        = TABLE_DEPTH_DEF;
	localparam int IDLE_LIMIT   = 2000;
	localparam int HOLD_AFTER   = 40;
	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_ITEMS = 170;
	localparam int REPEATS_A    = 5;

	typedef struct {
		bit               kind;
		logic [KEY_W-1:0] key;
		bit               drain_first;  // hold off until every result is back
	} key_event_t;

	typedef struct {
		bit                 passed;
		bit                 report_valid;
		logic [KEY_W-1:0]   report_key;
		logic [COUNT_W-1:0] report_count;
		bit                 last;
	} verdict_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [KEY_W-1:0]         s_tdata = '0;
	logic [0:0]               s_tuser = '0;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [KEY_W+COUNT_W-1:0] m_tdata;
	logic [1:0]               m_tuser;
	logic                     m_tlast;

	key_event_t event_queue[$];
	verdict_t   verdicts_due[$];

	// predictor state
	logic [KEY_W-1:0]   seen_keys[DEPTH];
	logic [COUNT_W-1:0] seen_counts[DEPTH];
	int                 seen_fill = 0;

	int n_errors = 0;
	int idle_cycles = 0;
	int n_in_taken = 0;
	bit in_xfer = 1'b0;
	int burst_left = 4;
	int gap_left = 0;
	int phase_left = 0;
	int rx_mode = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	repeat_event_suppressor_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	function automatic void add_event(bit kind, logic [KEY_W-1:0] key, bit drain_first);
		key_event_t it;
		it.kind = kind;
		it.key = key;
		it.drain_first = drain_first;
		event_queue.push_back(it);
	endfunction

	// works out the results one accepted transfer causes and updates the table copy
	function automatic void screen_event(key_event_t it);
		verdict_t v;
		bit       hit;
		v = '{1'b0, 1'b0, '0, '0, 1'b0};
		hit = 1'b0;
		if (it.kind == KIND_TICK) begin
			for (int i = 0; i < seen_fill; i++) begin
				if (seen_counts[i] > COUNT_ONE) begin
					v = '{1'b0, 1'b1, seen_keys[i], seen_counts[i], 1'b0};
					verdicts_due.push_back(v);
				end
			end
			seen_fill = 0;
			v = '{1'b0, 1'b0, '0, '0, 1'b1};
			verdicts_due.push_back(v);
		end else begin
			for (int i = 0; i < seen_fill; i++) begin
				if (!hit && seen_keys[i] == it.key) begin
					hit = 1'b1;
					if (seen_counts[i] != COUNT_MAX)
						seen_counts[i] = seen_counts[i] + COUNT_ONE;
				end
			end
			// a new key finding the table full passes but is not stored
			if (!hit && seen_fill < DEPTH) begin
				seen_keys[seen_fill] = it.key;
				seen_counts[seen_fill] = COUNT_ONE;
				seen_fill++;
			end
			v = '{!hit, 1'b0, '0, '0, 1'b1};
			verdicts_due.push_back(v);
		end
	endfunction

	// handshake sampling and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			in_xfer <= s_tvalid && s_tready;
			if (s_tvalid && s_tready)
				n_in_taken <= n_in_taken + 1;
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("repeat_event_suppressor_core_tb NOT OK");
				$finish;
			end
		end
	end

	// input driver: bursts of transfers with random gaps
	always @(negedge clk) begin
		bit offer;
		offer = 1'b0;
		if (in_xfer) begin
			screen_event(event_queue[0]);
			void'(event_queue.pop_front());
			if (burst_left > 0)
				burst_left--;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 16);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			end
		end
		if (!arst_n)
			offer = 1'b0;
		else if (s_tvalid && !in_xfer)
			offer = 1'b1;
		else if (event_queue.size() != 0) begin
			if (gap_left > 0)
				gap_left--;
			else if (event_queue[0].drain_first && verdicts_due.size() != 0)
				offer = 1'b0;
			else
				offer = 1'b1;
		end
		s_tvalid <= offer;
		if (offer) begin
			s_tdata <= event_queue[0].key;
			s_tuser <= event_queue[0].kind;
		end
	end

	// output ready: phases of full rate, light and heavy stalls, one long hold-off
	always @(negedge clk) begin
		bit rdy;
		if (phase_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			phase_left = $urandom_range(5, 60);
		end
		phase_left--;
		if (!hold_done && n_in_taken >= HOLD_AFTER) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			rdy = 1'b0;
		end else begin
			case (rx_mode)
				0: rdy = 1'b1;
				1: rdy = ($urandom_range(0, 3) != 0);
				default: rdy = ($urandom_range(0, 3) == 0);
			endcase
		end
		m_tready <= rdy;
	end

	// output monitor
	always @(posedge clk) begin
		verdict_t exp_v;
		if (arst_n && m_tvalid && m_tready) begin
			if (verdicts_due.size() == 0) begin
				$error("unexpected result transfer: tdata %h tuser %b tlast %b",
					m_tdata, m_tuser, m_tlast);
				n_errors++;
			end else begin
				exp_v = verdicts_due.pop_front();
				if (m_tuser[UB_PASSED] !== exp_v.passed) begin
					$error("passed: expected %0d, got %0d", exp_v.passed, m_tuser[UB_PASSED]);
					n_errors++;
				end
				if (m_tuser[UB_REPORT] !== exp_v.report_valid) begin
					$error("report_valid: expected %0d, got %0d",
						exp_v.report_valid, m_tuser[UB_REPORT]);
					n_errors++;
				end
				if (m_tdata[KEY_W-1:0] !== exp_v.report_key) begin
					$error("report_key: expected %h, got %h",
						exp_v.report_key, m_tdata[KEY_W-1:0]);
					n_errors++;
				end
				if (m_tdata[KEY_W+COUNT_W-1:KEY_W] !== exp_v.report_count) begin
					$error("report_count: expected %0d, got %0d",
						exp_v.report_count, m_tdata[KEY_W+COUNT_W-1:KEY_W]);
					n_errors++;
				end
				if (m_tlast !== exp_v.last) begin
					$error("last: expected %0d, got %0d", exp_v.last, m_tlast);
					n_errors++;
				end
			end
		end
	end

	initial begin
		int               n_random;
		int               period_len;
		int               pool_size;
		int               period_no;
		logic [KEY_W-1:0] key_pool[24];
		logic [KEY_W-1:0] key_a;
		logic [KEY_W-1:0] key_b;

		// tick on an empty table, repeats at both key extremes, then fill the table
		add_event(KIND_TICK, '0, 1'b0);
		add_event(KIND_EVENT, '0, 1'b0);
		add_event(KIND_EVENT, '0, 1'b0);
		repeat (4)
			add_event(KIND_EVENT, {KEY_W{1'b1}}, 1'b0);
		for (int i = 0; i < DEPTH - 2; i++)
			add_event(KIND_EVENT, KEY_W'(1) << i, 1'b0);
		// table full: a new key passes every time
		add_event(KIND_EVENT, 32'hA5A5_5A5A, 1'b0);
		add_event(KIND_EVENT, 32'hA5A5_5A5A, 1'b0);
		add_event(KIND_TICK, '0, 1'b0);

		// random periods drawn from small key pools so repeats are common
		n_random = 0;
		period_no = 0;
		while (n_random < RANDOM_ITEMS) begin
			period_len = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 30);
			pool_size = $urandom_range(1, 24);
			for (int i = 0; i < pool_size; i++)
				key_pool[i] = $urandom;
			for (int i = 0; i < period_len; i++) begin
				if ($urandom_range(0, 9) == 0)
					add_event(KIND_EVENT, $urandom, (i == 0) && (period_no % 4 == 0));
				else
					add_event(KIND_EVENT, key_pool[$urandom_range(0, pool_size - 1)],
						(i == 0) && (period_no % 4 == 0));
			end
			add_event(KIND_TICK, $urandom, (period_len == 0) && (period_no % 4 == 0));
			n_random += period_len + 1;
			period_no++;
		end

		// repeats on one key with a second key reported beside it
		key_a = $urandom;
		key_b = ~key_a;
		add_event(KIND_EVENT, key_a, 1'b1);
		add_event(KIND_EVENT, key_b, 1'b0);
		repeat (REPEATS_A)
			add_event(KIND_EVENT, key_a, 1'b0);
		add_event(KIND_EVENT, key_b, 1'b0);
		add_event(KIND_TICK, '0, 1'b0);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (event_queue.size() != 0 || verdicts_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (n_errors == 0 && verdicts_due.size() == 0)
			$display("repeat_event_suppressor_core_tb OK");
		else
			$display("repeat_event_suppressor_core_tb NOT OK");
		$finish;
	end

endmodule
